// File: rtl/ssw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_pkg
// shared constants, register indexes and the segment code table for the
// two-wire segment display sender
// ----------------------------------------------------------------------------
package ssw_pkg;

  localparam int unsigned DigitCountDef = 4;
  localparam int unsigned HeldDigits    = 4;
  localparam int unsigned DigitW        = 4;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 3;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_DISPLAY_ON    = 2'd0,
    CFG_BRIGHTNESS    = 2'd1,
    CFG_FIXED_ADDRESS = 2'd2,
    CFG_START_COLUMN  = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] CmdData      = 8'b0100_0000;
  localparam logic [7:0] CmdDataFixed = 8'b0000_0100;
  localparam logic [7:0] CmdAddr      = 8'b1100_0000;
  localparam logic [7:0] CmdCtrl      = 8'b1000_0000;
  localparam logic [7:0] CmdCtrlOn    = 8'b0000_1000;
  localparam logic [7:0] SegBlank     = 8'b0000_0000;

  // segment result of one accepted word
  typedef struct packed {
    logic load_rejected;
    logic busy_res;
    logic data_line;
    logic clock_line;
  } result_t;

  // seven segment code for a decimal digit, blank above nine
  function automatic logic [7:0] seg_code(input logic [DigitW-1:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'b0011_1111;
      4'd1:    code = 8'b0000_0110;
      4'd2:    code = 8'b0101_1011;
      4'd3:    code = 8'b0100_1111;
      4'd4:    code = 8'b0110_0110;
      4'd5:    code = 8'b0110_1101;
      4'd6:    code = 8'b0111_1100;
      4'd7:    code = 8'b0000_0111;
      4'd8:    code = 8'b0111_1111;
      4'd9:    code = 8'b0110_0111;
      default: code = SegBlank;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/seven_segment_two_wire_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_two_wire_sender
// drives the clock and data pins of a two-wire segment display controller,
// one half-bit phase per tick word
// ----------------------------------------------------------------------------
// Every input word is handled as it is accepted: the bus sequencer steps once
// per word in a single pass of logic and writes its result into a two-entry
// output stage, so a word can be accepted in every cycle and s_axis_tready
// only drops when both output entries are full. A load word (tuser low)
// latches the digits and starts a frame; each tick word (tuser high) moves
// the pins by one half-bit phase. A full frame with four digits takes 145
// ticks. Configuration is sampled as each command byte is loaded.
module seven_segment_two_wire_sender #(
  parameter int unsigned DIGIT_COUNT = ssw_pkg::DigitCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [ssw_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [ssw_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input words
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // digit_first, digit_second, digit_third, digit_fourth
  input  logic [ssw_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type
  input  logic                          s_axis_tuser,
  // result words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // clock_line, data_line, busy_res, load_rejected, zero fill
  output logic [ssw_pkg::OutDataW-1:0]  m_axis_tdata,
  // frame_done
  output logic                          m_axis_tlast
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_BIT_LOW  = 4'd3,
    PH_BIT_HIGH = 4'd4,
    PH_ACK_LOW  = 4'd5,
    PH_ACK_HIGH = 4'd6,
    PH_ACK_END  = 4'd7,
    PH_STOP_A   = 4'd8,
    PH_STOP_B   = 4'd9
  } phase_e;

  localparam logic [3:0] AddrTxnBytes = 4'(1 + DIGIT_COUNT);

  // configuration registers
  logic       display_on_q, fixed_address_q;
  logic [2:0] brightness_q, start_column_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_on_q    <= 1'b1;
      brightness_q    <= 3'd2;
      fixed_address_q <= 1'b0;
      start_column_q  <= 3'd0;
    end else if (cfg_we_i) begin
      case (ssw_pkg::cfg_idx_e'(cfg_addr_i))
        ssw_pkg::CFG_DISPLAY_ON:    display_on_q    <= cfg_wdata_i[0];
        ssw_pkg::CFG_BRIGHTNESS:    brightness_q    <= cfg_wdata_i;
        ssw_pkg::CFG_FIXED_ADDRESS: fixed_address_q <= cfg_wdata_i[0];
        ssw_pkg::CFG_START_COLUMN:  start_column_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_e     phase_q, phase_d;
  logic [1:0] txn_q, txn_d;
  logic [2:0] byte_idx_q, byte_idx_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic [ssw_pkg::DigitW-1:0] held_q [ssw_pkg::HeldDigits];
  logic [ssw_pkg::DigitW-1:0] held_d [ssw_pkg::HeldDigits];
  logic       clk_line_q, clk_line_d;
  logic       dat_line_q, dat_line_d;
  logic       active_q, active_d;
  logic       done, rejected;

  logic       push, pop;
  logic       out_valid_q, skid_valid_q;
  ssw_pkg::result_t out_q, skid_q, res;
  logic       out_last_q, skid_last_q;

  assign s_axis_tready = !skid_valid_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid_q && m_axis_tready;

  // byte selection for the next byte to shift out
  logic [2:0] nb_idx, inc_idx, seg_k;
  logic [7:0] next_byte;

  assign inc_idx = byte_idx_q + 3'd1;
  assign nb_idx  = (phase_q == PH_START_B) ? 3'd0 : inc_idx;
  assign seg_k   = nb_idx - 3'd1;

  always_comb begin
    case (txn_q)
      2'd0: next_byte = ssw_pkg::CmdData | (fixed_address_q ? ssw_pkg::CmdDataFixed : 8'h00);
      2'd1: begin
        if (nb_idx == 3'd0) begin
          next_byte = ssw_pkg::CmdAddr | {5'd0, start_column_q};
        end else if (seg_k < 3'(ssw_pkg::HeldDigits)) begin
          next_byte = ssw_pkg::seg_code(held_q[seg_k[1:0]]);
        end else begin
          next_byte = ssw_pkg::SegBlank;
        end
      end
      default: next_byte = ssw_pkg::CmdCtrl | (display_on_q ? ssw_pkg::CmdCtrlOn : 8'h00)
                           | {5'd0, brightness_q};
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    txn_d      = txn_q;
    byte_idx_d = byte_idx_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    held_d     = held_q;
    clk_line_d = clk_line_q;
    dat_line_d = dat_line_q;
    active_d   = active_q;
    done       = 1'b0;
    rejected   = 1'b0;
    if (push) begin
      if (!s_axis_tuser) begin
        if (active_q) begin
          rejected = 1'b1;
        end else begin
          for (int i = 0; i < int'(ssw_pkg::HeldDigits); i++) begin
            held_d[i] = s_axis_tdata[i*ssw_pkg::DigitW +: ssw_pkg::DigitW];
          end
          active_d   = 1'b1;
          txn_d      = 2'd0;
          byte_idx_d = 3'd0;
          bit_idx_d  = 3'd0;
          phase_d    = PH_START_A;
          clk_line_d = 1'b1;
          dat_line_d = 1'b1;
        end
      end else if (active_q) begin
        case (phase_q)
          PH_START_A: begin
            clk_line_d = 1'b1;
            dat_line_d = 1'b0;
            phase_d    = PH_START_B;
          end
          PH_START_B: begin
            clk_line_d = 1'b0;
            dat_line_d = 1'b0;
            byte_idx_d = 3'd0;
            bit_idx_d  = 3'd0;
            shift_d    = next_byte;
            phase_d    = PH_BIT_LOW;
          end
          PH_BIT_LOW: begin
            clk_line_d = 1'b0;
            dat_line_d = shift_q[0];
            phase_d    = PH_BIT_HIGH;
          end
          PH_BIT_HIGH: begin
            clk_line_d = 1'b1;
            dat_line_d = shift_q[0];
            shift_d    = {1'b0, shift_q[7:1]};
            if (bit_idx_q == 3'd7) begin
              bit_idx_d = 3'd0;
              phase_d   = PH_ACK_LOW;
            end else begin
              bit_idx_d = bit_idx_q + 3'd1;
              phase_d   = PH_BIT_LOW;
            end
          end
          PH_ACK_LOW: begin
            clk_line_d = 1'b0;
            dat_line_d = 1'b0;
            phase_d    = PH_ACK_HIGH;
          end
          PH_ACK_HIGH: begin
            clk_line_d = 1'b1;
            dat_line_d = 1'b0;
            phase_d    = PH_ACK_END;
          end
          PH_ACK_END: begin
            clk_line_d = 1'b0;
            dat_line_d = 1'b0;
            byte_idx_d = inc_idx;
            // only the address transaction carries more than one byte
            if (inc_idx != 3'd0 && txn_q == 2'd1 && {1'b0, inc_idx} < AddrTxnBytes) begin
              shift_d   = next_byte;
              bit_idx_d = 3'd0;
              phase_d   = PH_BIT_LOW;
            end else begin
              phase_d = PH_STOP_A;
            end
          end
          PH_STOP_A: begin
            clk_line_d = 1'b1;
            dat_line_d = 1'b0;
            phase_d    = PH_STOP_B;
          end
          default: begin
            clk_line_d = 1'b1;
            dat_line_d = 1'b1;
            byte_idx_d = 3'd0;
            bit_idx_d  = 3'd0;
            if (txn_q >= 2'd2) begin
              txn_d    = 2'd0;
              active_d = 1'b0;
              phase_d  = PH_IDLE;
              done     = 1'b1;
            end else begin
              txn_d   = txn_q + 2'd1;
              phase_d = PH_START_A;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    res.clock_line    = clk_line_d;
    res.data_line     = dat_line_d;
    res.busy_res      = active_d;
    res.load_rejected = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      txn_q      <= 2'd0;
      byte_idx_q <= 3'd0;
      bit_idx_q  <= 3'd0;
      shift_q    <= 8'd0;
      for (int i = 0; i < int'(ssw_pkg::HeldDigits); i++) begin
        held_q[i] <= '0;
      end
      clk_line_q <= 1'b1;
      dat_line_q <= 1'b1;
      active_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      txn_q      <= txn_d;
      byte_idx_q <= byte_idx_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      held_q     <= held_d;
      clk_line_q <= clk_line_d;
      dat_line_q <= dat_line_d;
      active_q   <= active_d;
    end
  end

  // two-entry output stage: result register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q      <= skid_q;
        out_last_q <= skid_last_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q      <= res;
        out_last_q <= done;
      end else begin
        skid_q      <= res;
        skid_last_q <= done;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/ssw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_sva_checker
// port-level checks for the two-wire segment display sender
// ----------------------------------------------------------------------------
module ssw_sva_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [ssw_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input logic [ssw_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [ssw_pkg::InDataW-1:0]   s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ssw_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast
);

  ssw_pkg::result_t res;
  assign res = ssw_pkg::result_t'(m_axis_tdata[3:0]);

  // a word offered downstream stays offered until taken
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word withdrawn before it was taken");

  // the word that ends a frame already shows the sender idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !res.busy_res && !res.load_rejected)
    else $error("frame end word shows busy or rejected");

  // a rejected load means a frame was still running
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.load_rejected |-> res.busy_res)
    else $error("load rejected while idle");

  // with no frame running both bus lines rest high
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.busy_res |-> res.clock_line && res.data_line)
    else $error("bus lines not released while idle");

endmodule

bind seven_segment_two_wire_sender ssw_sva_checker u_ssw_checker (.*);
